// ===== sv/mpts_pkg.sv =====
// shared types, codes and defaults for the multi-policy task scheduler
package mpts_pkg;

    localparam int MAX_TASKS = 16;
    localparam int TIME_BITS = 16;
    localparam int MAX_LEVEL = 7;

    // operation codes
    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;
    localparam logic [1:0] OP_NOP   = 2'd3;

    // policy codes
    localparam logic [2:0] POL_RR   = 3'd0;
    localparam logic [2:0] POL_FCFS = 3'd1;
    localparam logic [2:0] POL_SPN  = 3'd2;
    localparam logic [2:0] POL_HRRN = 3'd3;
    localparam logic [2:0] POL_SRT  = 3'd4;
    localparam logic [2:0] POL_FB   = 3'd5;

    // configuration register indexes
    localparam logic [1:0] CFG_POLICY     = 2'd0;
    localparam logic [1:0] CFG_QUANTUM    = 2'd1;
    localparam logic [1:0] CFG_TIME_LIMIT = 2'd2;
    localparam logic [1:0] CFG_TASK_COUNT = 2'd3;

    // configuration reset values
    localparam logic [2:0]  POLICY_RST     = POL_RR;
    localparam logic [15:0] QUANTUM_RST    = 16'd4;
    localparam logic [15:0] TIME_LIMIT_RST = 16'hFFFF;
    localparam logic [4:0]  TASK_COUNT_RST = 5'd16;

    typedef struct packed {
        logic [1:0]  operation;
        logic [3:0]  task_slot;
        logic [15:0] arrival_time;
        logic [15:0] service_time;
    } in_item_t;

    typedef struct packed {
        logic [3:0]  running_slot;
        logic        running_valid;
        logic        dispatched;
        logic        first_start;
        logic [3:0]  ended_slot;
        logic        ended_finished;
        logic        ended_preempted;
        logic [15:0] now_time;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TICK_RD,
        ST_TICK_EV,
        ST_DISP,
        ST_REDUCE,
        ST_SCAN_RD,
        ST_SCAN_EV,
        ST_COMMIT,
        ST_DONE
    } state_t;

endpackage

// ===== sv/multi_policy_task_scheduler_core.sv =====
// multi-policy task scheduler top level: task table memory, tick engine and dispatch scan
//
// Task scheduler over a table of MAX_TASKS slots holding arrival, service, executed time,
// feedback level and done/started flags in one synchronous single-port-read table memory.
// Policies: round robin, first come, shortest next, highest response ratio, shortest
// remaining and multi-level feedback. One result transfer follows every input transfer.
// A load or no-op goes straight to its result; a tick with a running task first does the
// read-modify-write of that task's entry. After a start or a tick, whenever the processor is
// free and time is below the limit, a dispatch scan follows: it walks slots 0..task_count-1
// through the table's read port one slot at a time (read, then compare with the registered
// best) and then commits any winner; the cyclic policies first fold the cursor into range by
// repeated subtraction of the task count. A start clears all per-slot progress at once
// through per-slot fresh bits; no clearing pass is needed. Configuration writes are taken in
// any cycle but must only be issued while the block is idle.
module multi_policy_task_scheduler_core #(
    parameter int MAX_TASKS = mpts_pkg::MAX_TASKS,
    parameter int MAX_LEVEL = mpts_pkg::MAX_LEVEL
) (
    input  logic                aclk,
    input  logic                aresetn,
    // item input
    input  logic                s_valid,
    output logic                s_ready,
    input  mpts_pkg::in_item_t  s_data,
    // result output
    output logic                m_valid,
    input  logic                m_ready,
    output mpts_pkg::out_item_t m_data,
    // configuration writes
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_addr,
    input  logic [15:0]         cfg_data
);

    localparam int TW     = mpts_pkg::TIME_BITS;
    localparam int SLOT_W = $clog2(MAX_TASKS);
    localparam int CNT_W  = $clog2(MAX_TASKS + 1);
    localparam int LVL_W  = $clog2(MAX_LEVEL + 1);
    localparam int SL_W   = TW + MAX_LEVEL;
    // table entry layout: arrival | service | executed | level | done | started
    localparam int O_LVL  = 2;
    localparam int O_EXE  = O_LVL + LVL_W;
    localparam int O_SRV  = O_EXE + TW;
    localparam int O_ARR  = O_SRV + TW;
    localparam int E_W    = O_ARR + TW;
    localparam logic [TW-1:0]    TIME_MAX  = {TW{1'b1}};
    localparam logic [SL_W-1:0]  SLICE_MAX = {SL_W{1'b1}};
    localparam logic [LVL_W-1:0] LVL_MAX   = LVL_W'(MAX_LEVEL);

    // fsm
    mpts_pkg::state_t state_reg, state_next;

    // configuration
    logic [2:0]  policy_reg, policy_next;
    logic [15:0] quantum_reg, quantum_next;
    logic [15:0] limit_reg, limit_next;
    logic [4:0]  count_reg, count_next;

    // scheduler state
    logic [TW-1:0]        time_reg, time_next;
    logic [SLOT_W-1:0]    run_slot_reg, run_slot_next;
    logic                 run_act_reg, run_act_next;
    logic [SL_W-1:0]      slice_reg, slice_next;
    logic [SLOT_W-1:0]    cursor_reg, cursor_next;
    logic [MAX_TASKS-1:0] fresh_reg, fresh_next;   // entry progress fields valid

    // per-item report
    logic              disp_reg, disp_next;
    logic              first_reg, first_next;
    logic [SLOT_W-1:0] ended_reg, ended_next;
    logic              fin_reg, fin_next;
    logic              pre_reg, pre_next;

    // scan pipeline
    logic [SLOT_W-1:0] scan_slot_reg, scan_slot_next;
    logic [CNT_W-1:0]  scan_cnt_reg, scan_cnt_next;
    logic [SLOT_W-1:0] rd_slot_reg, rd_slot_next;
    logic              pend_reg, pend_next;
    logic              found_reg, found_next;
    logic              cand_ready_reg, cand_ready_next;
    logic [E_W-1:0]    cand_entry_reg, cand_entry_next;
    logic [SLOT_W-1:0] cand_slot_reg, cand_slot_next;
    logic [TW-1:0]     cand_wait_reg, cand_wait_next;
    logic [TW-1:0]     cand_rem_reg, cand_rem_next;
    logic              cand_better_reg, cand_better_next;
    logic [2*TW-1:0]   prod_c_reg, prod_c_next;
    logic [2*TW-1:0]   prod_b_reg, prod_b_next;
    logic [SLOT_W-1:0] best_slot_reg, best_slot_next;
    logic [E_W-1:0]    best_entry_reg, best_entry_next;
    logic [TW-1:0]     best_wait_reg, best_wait_next;
    logic [TW-1:0]     best_rem_reg, best_rem_next;

    // output register
    logic                m_valid_reg, m_valid_next;
    mpts_pkg::out_item_t m_data_reg, m_data_next;

    // table memory
    logic [E_W-1:0]    mem [MAX_TASKS];
    logic              mem_we;
    logic [SLOT_W-1:0] mem_waddr;
    logic [E_W-1:0]    mem_wdata;
    logic [SLOT_W-1:0] mem_raddr;
    logic [E_W-1:0]    mem_rdata_reg;
    logic              rd_fresh_reg;

    // decoded helpers
    logic [CNT_W-1:0]  tc;
    logic              cyclic;
    logic              preemptive;
    logic [E_W-1:0]    rd_entry;
    logic [TW-1:0]     rd_arr, rd_srv, rd_exe;
    logic [LVL_W-1:0]  rd_lvl;
    logic              rd_done;
    logic [TW-1:0]     exe_inc;
    logic [SL_W-1:0]   slice_inc;
    logic [SL_W-1:0]   slice_lim;
    logic [15:0]       q_eff;
    logic [TW-1:0]     rd_wait, rd_rem;
    logic              take;
    logic [SLOT_W-1:0] ld_slot;
    logic              ld_ok;
    mpts_pkg::out_item_t out_item;

    assign s_ready   = (state_reg == mpts_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= mem[mem_raddr];
        rd_fresh_reg  <= fresh_reg[mem_raddr];
    end

    // a stale entry reads with its progress fields at zero
    assign rd_entry = rd_fresh_reg ? mem_rdata_reg
                                   : {mem_rdata_reg[E_W-1:O_SRV], {O_SRV{1'b0}}};
    assign rd_arr  = rd_entry[O_ARR +: TW];
    assign rd_srv  = rd_entry[O_SRV +: TW];
    assign rd_exe  = rd_entry[O_EXE +: TW];
    assign rd_lvl  = rd_entry[O_LVL +: LVL_W];
    assign rd_done = rd_entry[1];
    assign rd_wait = time_reg - rd_arr;
    assign rd_rem  = (rd_exe >= rd_srv) ? '0 : (rd_srv - rd_exe);

    // effective task count, clamped to 1..MAX_TASKS
    always_comb begin
        if (count_reg == 5'd0) begin
            tc = CNT_W'(1);
        end else if (32'(count_reg) > 32'(MAX_TASKS)) begin
            tc = CNT_W'(MAX_TASKS);
        end else begin
            tc = CNT_W'(count_reg);
        end
    end

    // unknown policy codes fall back to round robin
    assign cyclic     = (policy_reg == mpts_pkg::POL_RR) || (policy_reg == mpts_pkg::POL_FCFS)
                        || (policy_reg > mpts_pkg::POL_FB);
    assign preemptive = !((policy_reg == mpts_pkg::POL_FCFS)
                        || (policy_reg == mpts_pkg::POL_SPN)
                        || (policy_reg == mpts_pkg::POL_HRRN));

    assign q_eff     = (quantum_reg == 16'd0) ? 16'd1 : quantum_reg;
    assign slice_lim = (policy_reg == mpts_pkg::POL_FB) ? (SL_W'(q_eff) << rd_lvl)
                                                         : SL_W'(q_eff);
    assign exe_inc   = (rd_exe < TIME_MAX) ? rd_exe + 1'b1 : rd_exe;
    assign slice_inc = (slice_reg < SLICE_MAX) ? slice_reg + 1'b1 : slice_reg;

    assign ld_slot = SLOT_W'(s_data.task_slot);
    assign ld_ok   = (32'(s_data.task_slot) < 32'(MAX_TASKS));

    // winner test for the registered candidate; exact cross products for response ratio
    always_comb begin
        if (!cand_ready_reg) begin
            take = 1'b0;
        end else if (!found_reg) begin
            take = 1'b1;
        end else if (policy_reg == mpts_pkg::POL_HRRN) begin
            take = (prod_c_reg > prod_b_reg);
        end else begin
            take = cand_better_reg;
        end
    end

    always_comb begin
        out_item.running_slot    = run_act_reg ? 4'(run_slot_reg) : 4'd0;
        out_item.running_valid   = run_act_reg;
        out_item.dispatched      = disp_reg;
        out_item.first_start     = first_reg;
        out_item.ended_slot      = 4'(ended_reg);
        out_item.ended_finished  = fin_reg;
        out_item.ended_preempted = pre_reg;
        out_item.now_time        = 16'(time_reg);
    end

    always_comb begin
        state_next       = state_reg;
        policy_next      = policy_reg;
        quantum_next     = quantum_reg;
        limit_next       = limit_reg;
        count_next       = count_reg;
        time_next        = time_reg;
        run_slot_next    = run_slot_reg;
        run_act_next     = run_act_reg;
        slice_next       = slice_reg;
        cursor_next      = cursor_reg;
        fresh_next       = fresh_reg;
        disp_next        = disp_reg;
        first_next       = first_reg;
        ended_next       = ended_reg;
        fin_next         = fin_reg;
        pre_next         = pre_reg;
        scan_slot_next   = scan_slot_reg;
        scan_cnt_next    = scan_cnt_reg;
        rd_slot_next     = rd_slot_reg;
        pend_next        = pend_reg;
        found_next       = found_reg;
        cand_ready_next  = cand_ready_reg;
        cand_entry_next  = cand_entry_reg;
        cand_slot_next   = cand_slot_reg;
        cand_wait_next   = cand_wait_reg;
        cand_rem_next    = cand_rem_reg;
        cand_better_next = cand_better_reg;
        prod_c_next      = prod_c_reg;
        prod_b_next      = prod_b_reg;
        best_slot_next   = best_slot_reg;
        best_entry_next  = best_entry_reg;
        best_wait_next   = best_wait_reg;
        best_rem_next    = best_rem_reg;
        m_valid_next     = m_valid_reg;
        m_data_next      = m_data_reg;
        mem_we           = 1'b0;
        mem_waddr        = run_slot_reg;
        mem_wdata        = rd_entry;
        mem_raddr        = scan_slot_reg;

        // config transfer
        if (cfg_valid) begin
            case (cfg_addr)
                mpts_pkg::CFG_POLICY:     policy_next  = cfg_data[2:0];
                mpts_pkg::CFG_QUANTUM:    quantum_next = cfg_data;
                mpts_pkg::CFG_TIME_LIMIT: limit_next   = cfg_data;
                mpts_pkg::CFG_TASK_COUNT: count_next   = cfg_data[4:0];
                default:                  count_next   = count_reg;
            endcase
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            mpts_pkg::ST_IDLE: begin
                if (s_valid) begin
                    disp_next  = 1'b0;
                    first_next = 1'b0;
                    ended_next = '0;
                    fin_next   = 1'b0;
                    pre_next   = 1'b0;
                    case (s_data.operation)
                        mpts_pkg::OP_LOAD: begin
                            // fresh slot; a running slot is dropped silently
                            if (ld_ok) begin
                                mem_we    = 1'b1;
                                mem_waddr = ld_slot;
                                mem_wdata = {TW'(s_data.arrival_time), TW'(s_data.service_time),
                                             {O_SRV{1'b0}}};
                                fresh_next[ld_slot] = 1'b1;
                                if (run_act_reg && (run_slot_reg == ld_slot)) begin
                                    run_act_next = 1'b0;
                                end
                            end
                            state_next = mpts_pkg::ST_DONE;
                        end
                        mpts_pkg::OP_START: begin
                            fresh_next    = '0;
                            time_next     = '0;
                            run_slot_next = '0;
                            run_act_next  = 1'b0;
                            slice_next    = '0;
                            cursor_next   = '0;
                            state_next    = mpts_pkg::ST_DISP;
                        end
                        mpts_pkg::OP_TICK: begin
                            if (run_act_reg) begin
                                state_next = mpts_pkg::ST_TICK_RD;
                            end else begin
                                time_next  = (time_reg < TIME_MAX) ? time_reg + 1'b1 : time_reg;
                                state_next = mpts_pkg::ST_DISP;
                            end
                        end
                        default: begin
                            state_next = mpts_pkg::ST_DONE;
                        end
                    endcase
                end
            end
            mpts_pkg::ST_TICK_RD: begin
                mem_raddr  = run_slot_reg;
                state_next = mpts_pkg::ST_TICK_EV;
            end
            mpts_pkg::ST_TICK_EV: begin
                // running entry: count, then finish before slice end
                mem_we    = 1'b1;
                mem_waddr = run_slot_reg;
                mem_wdata = rd_entry;
                mem_wdata[O_EXE +: TW] = exe_inc;
                fresh_next[run_slot_reg] = 1'b1;
                slice_next = slice_inc;
                time_next  = (time_reg < TIME_MAX) ? time_reg + 1'b1 : time_reg;
                if (exe_inc >= rd_srv) begin
                    mem_wdata[1] = 1'b1;
                    fin_next     = 1'b1;
                    ended_next   = run_slot_reg;
                    run_act_next = 1'b0;
                end else if (preemptive && (slice_inc >= slice_lim)) begin
                    pre_next     = 1'b1;
                    ended_next   = run_slot_reg;
                    run_act_next = 1'b0;
                    if ((policy_reg == mpts_pkg::POL_FB) && (rd_lvl < LVL_MAX)) begin
                        mem_wdata[O_LVL +: LVL_W] = rd_lvl + 1'b1;
                    end
                end
                state_next = mpts_pkg::ST_DISP;
            end
            mpts_pkg::ST_DISP: begin
                if (!run_act_reg && (time_reg < TW'(limit_reg))) begin
                    found_next     = 1'b0;
                    pend_next      = 1'b0;
                    scan_cnt_next  = '0;
                    scan_slot_next = cyclic ? cursor_reg : '0;
                    state_next     = cyclic ? mpts_pkg::ST_REDUCE : mpts_pkg::ST_SCAN_RD;
                end else begin
                    state_next = mpts_pkg::ST_DONE;
                end
            end
            mpts_pkg::ST_REDUCE: begin
                // cursor modulo task count, one subtract per cycle
                if (32'(scan_slot_reg) >= 32'(tc)) begin
                    scan_slot_next = SLOT_W'(32'(scan_slot_reg) - 32'(tc));
                end else begin
                    state_next = mpts_pkg::ST_SCAN_RD;
                end
            end
            mpts_pkg::ST_SCAN_RD: begin
                if (pend_reg && take) begin
                    found_next      = 1'b1;
                    best_slot_next  = cand_slot_reg;
                    best_entry_next = cand_entry_reg;
                    best_wait_next  = cand_wait_reg;
                    best_rem_next   = cand_rem_reg;
                end
                pend_next = 1'b0;
                if (scan_cnt_reg == tc) begin
                    state_next = mpts_pkg::ST_COMMIT;
                end else begin
                    mem_raddr     = scan_slot_reg;
                    rd_slot_next  = scan_slot_reg;
                    scan_cnt_next = scan_cnt_reg + 1'b1;
                    if (32'(scan_slot_reg) + 32'd1 == 32'(tc)) begin
                        scan_slot_next = '0;
                    end else begin
                        scan_slot_next = scan_slot_reg + 1'b1;
                    end
                    state_next = mpts_pkg::ST_SCAN_EV;
                end
            end
            mpts_pkg::ST_SCAN_EV: begin
                cand_ready_next = !rd_done && (rd_arr <= time_reg);
                cand_entry_next = rd_entry;
                cand_slot_next  = rd_slot_reg;
                cand_wait_next  = rd_wait;
                cand_rem_next   = rd_rem;
                case (policy_reg)
                    mpts_pkg::POL_SPN: cand_better_next = rd_srv < best_entry_reg[O_SRV +: TW];
                    mpts_pkg::POL_SRT: cand_better_next = rd_rem < best_rem_reg;
                    mpts_pkg::POL_FB:  cand_better_next =
                                           rd_lvl < best_entry_reg[O_LVL +: LVL_W];
                    default:           cand_better_next = 1'b0;
                endcase
                prod_c_next = rd_wait * best_entry_reg[O_SRV +: TW];
                prod_b_next = best_wait_reg * rd_srv;
                pend_next   = 1'b1;
                state_next  = mpts_pkg::ST_SCAN_RD;
            end
            mpts_pkg::ST_COMMIT: begin
                if (found_reg) begin
                    run_slot_next = best_slot_reg;
                    run_act_next  = 1'b1;
                    slice_next    = '0;
                    disp_next     = 1'b1;
                    first_next    = !best_entry_reg[0];
                    mem_we        = 1'b1;
                    mem_waddr     = best_slot_reg;
                    mem_wdata     = best_entry_reg | E_W'(1);
                    fresh_next[best_slot_reg] = 1'b1;
                    if (32'(best_slot_reg) + 32'd1 == 32'(tc)) begin
                        cursor_next = '0;
                    end else begin
                        cursor_next = best_slot_reg + 1'b1;
                    end
                end
                state_next = mpts_pkg::ST_DONE;
            end
            mpts_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = out_item;
                    state_next   = mpts_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = mpts_pkg::ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= mpts_pkg::ST_IDLE;
            policy_reg    <= mpts_pkg::POLICY_RST;
            quantum_reg   <= mpts_pkg::QUANTUM_RST;
            limit_reg     <= mpts_pkg::TIME_LIMIT_RST;
            count_reg     <= mpts_pkg::TASK_COUNT_RST;
            time_reg      <= '0;
            run_slot_reg  <= '0;
            run_act_reg   <= 1'b0;
            slice_reg     <= '0;
            cursor_reg    <= '0;
            fresh_reg     <= '0;
            disp_reg      <= 1'b0;
            first_reg     <= 1'b0;
            ended_reg     <= '0;
            fin_reg       <= 1'b0;
            pre_reg       <= 1'b0;
            scan_slot_reg <= '0;
            scan_cnt_reg  <= '0;
            pend_reg      <= 1'b0;
            found_reg     <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            policy_reg    <= policy_next;
            quantum_reg   <= quantum_next;
            limit_reg     <= limit_next;
            count_reg     <= count_next;
            time_reg      <= time_next;
            run_slot_reg  <= run_slot_next;
            run_act_reg   <= run_act_next;
            slice_reg     <= slice_next;
            cursor_reg    <= cursor_next;
            fresh_reg     <= fresh_next;
            disp_reg      <= disp_next;
            first_reg     <= first_next;
            ended_reg     <= ended_next;
            fin_reg       <= fin_next;
            pre_reg       <= pre_next;
            scan_slot_reg <= scan_slot_next;
            scan_cnt_reg  <= scan_cnt_next;
            pend_reg      <= pend_next;
            found_reg     <= found_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // scan datapath and result payload
    always_ff @(posedge aclk) begin
        rd_slot_reg     <= rd_slot_next;
        cand_ready_reg  <= cand_ready_next;
        cand_entry_reg  <= cand_entry_next;
        cand_slot_reg   <= cand_slot_next;
        cand_wait_reg   <= cand_wait_next;
        cand_rem_reg    <= cand_rem_next;
        cand_better_reg <= cand_better_next;
        prod_c_reg      <= prod_c_next;
        prod_b_reg      <= prod_b_next;
        best_slot_reg   <= best_slot_next;
        best_entry_reg  <= best_entry_next;
        best_wait_reg   <= best_wait_next;
        best_rem_reg    <= best_rem_next;
        m_data_reg      <= m_data_next;
    end

`ifndef SYNTH
    // a committed winner always holds the processor afterwards
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == mpts_pkg::ST_COMMIT && found_reg) |=> run_act_reg)
        else $error("winner not dispatched");

    // a reported dispatch always leaves a running task
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (!m_data_reg.dispatched || m_data_reg.running_valid))
        else $error("dispatch without running task");

    // a task cannot both finish and be preempted on one tick
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(m_data_reg.ended_finished && m_data_reg.ended_preempted))
        else $error("finish and preempt together");

    // the scan never visits more slots than are in use
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == mpts_pkg::ST_SCAN_EV) |-> (scan_cnt_reg <= tc))
        else $error("scan ran past task count");
`endif

endmodule
